// ===== hw/rtl/hsvrgb_pkg.sv =====
// Shared types, constants and helpers for the HSV/RGB pixel converter.
// No dependencies; every module of the converter imports this package.
`timescale 1ns / 1ps

package hsvrgb_pkg;

    // Field widths
    localparam int CH_W  = 8;
    localparam int HUE_W = 9;

    // Pipeline geometry
    localparam int DIV_STEPS = 8;   // quotient bits, one per divider stage
    localparam int HSV_LAT   = 3;   // stages of the HSV to RGB datapath

    // Commands
    localparam logic CMD_HSV2RGB = 1'b0;
    localparam logic CMD_RGB2HSV = 1'b1;

    // Hue constants
    localparam logic [HUE_W-1:0] HUE_MAX = 9'd359;
    localparam logic [HUE_W-1:0] HUE_FULL = 9'd360;
    localparam logic [HUE_W-1:0] HUE_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BLUE = 9'd240;

    // Which channel holds the maximum (red wins ties, then green)
    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } t_sel;

    // Channel triple
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // Side information that travels alongside the divider lanes
    typedef struct packed {
        logic             cmd;
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
        t_rgb             pix;
        logic [CH_W-1:0]  mx;
        t_sel             sel;
        logic             neg;
        logic             dzero;
        logic             mzero;
    } t_side;

    // Truncating divide by 255 for products of two 8-bit values:
    // (x + 1 + x/256) / 256
    function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
        logic [2*CH_W:0] sum;
        sum = {1'b0, x} + 17'd1 + {9'd0, x[2*CH_W-1:CH_W]};
        return sum[2*CH_W-1:CH_W];
    endfunction

endpackage

// ===== hw/rtl/hsvrgb_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on hsvrgb_pkg for default widths.
`timescale 1ns / 1ps

module hsvrgb_div #(
    parameter int DEN_W = hsvrgb_pkg::CH_W,
    parameter int Q_W   = hsvrgb_pkg::DIV_STEPS
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [DEN_W+Q_W-1:0] i_num,   // must be below i_den * 2**Q_W
    input  logic [DEN_W-1:0]   i_den,
    output logic [Q_W-1:0]     o_quo
);
    import hsvrgb_pkg::*;

    logic [DEN_W-1:0] w_rem [Q_W+1];
    logic [Q_W-1:0]   w_lo  [Q_W+1];
    logic [Q_W-1:0]   w_q   [Q_W+1];
    logic [DEN_W-1:0] w_den [Q_W+1];

    assign w_rem[0] = i_num[DEN_W+Q_W-1:Q_W];
    assign w_lo[0]  = i_num[Q_W-1:0];
    assign w_q[0]   = '0;
    assign w_den[0] = i_den;

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] r_rem;
        logic [Q_W-1:0]   r_lo;
        logic [Q_W-1:0]   r_q;
        logic [DEN_W-1:0] r_den;

        // Shift in the next numerator bit and try a subtract
        always_comb begin
            trial = {w_rem[k], w_lo[k][Q_W-1]};
            ge    = (trial >= {1'b0, w_den[k]});
            diff  = ge ? (trial - {1'b0, w_den[k]}) : trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= diff[DEN_W-1:0];
                r_lo  <= {w_lo[k][Q_W-2:0], 1'b0};
                r_q   <= {w_q[k][Q_W-2:0], ge};
                r_den <= w_den[k];
            end
        end

        assign w_rem[k+1] = r_rem;
        assign w_lo[k+1]  = r_lo;
        assign w_q[k+1]   = r_q;
        assign w_den[k+1] = r_den;
    end

    assign o_quo = w_q[Q_W];

endmodule

// ===== hw/rtl/hsvrgb_hsv2rgb.sv =====
// Three-stage HSV to RGB datapath: products, divide by 255, sector mapping.
// Depends on hsvrgb_pkg for types and the divide-by-255 helper.
`timescale 1ns / 1ps

module hsvrgb_hsv2rgb (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [2:0]             i_sector,
    input  logic [hsvrgb_pkg::CH_W-1:0] i_frac,
    input  logic [hsvrgb_pkg::CH_W-1:0] i_sat,
    input  logic [hsvrgb_pkg::CH_W-1:0] i_val,
    output hsvrgb_pkg::t_rgb       o_rgb
);
    import hsvrgb_pkg::*;

    logic [2*CH_W-1:0] r1_mp, r1_msf, r1_mst;
    logic [CH_W-1:0]   r1_val;
    logic [2:0]        r1_sector;
    logic [CH_W-1:0]   r2_p, r2_val;
    logic [2*CH_W-1:0] r2_mq, r2_mt;
    logic [2:0]        r2_sector;
    t_rgb              r3_rgb;
    logic [CH_W-1:0]   w_sq, w_st, w_q, w_t;
    t_rgb              n_rgb;

    // Stage 1: first products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mp     <= 16'(i_val) * 16'(8'd255 - i_sat);
            r1_msf    <= 16'(i_sat) * 16'(i_frac);
            r1_mst    <= 16'(i_sat) * 16'(8'd255 - i_frac);
            r1_val    <= i_val;
            r1_sector <= i_sector;
        end
    end

    // Stage 2: scale down, second products
    assign w_sq = div255(r1_msf);
    assign w_st = div255(r1_mst);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p      <= div255(r1_mp);
            r2_mq     <= 16'(r1_val) * 16'(8'd255 - w_sq);
            r2_mt     <= 16'(r1_val) * 16'(8'd255 - w_st);
            r2_val    <= r1_val;
            r2_sector <= r1_sector;
        end
    end

    // Stage 3: scale down and map by sector
    assign w_q = div255(r2_mq);
    assign w_t = div255(r2_mt);

    always_comb begin
        unique case (r2_sector)
            3'd0:    n_rgb = '{red: r2_val, green: w_t,    blue: r2_p};
            3'd1:    n_rgb = '{red: w_q,    green: r2_val, blue: r2_p};
            3'd2:    n_rgb = '{red: r2_p,   green: r2_val, blue: w_t};
            3'd3:    n_rgb = '{red: r2_p,   green: w_q,    blue: r2_val};
            3'd4:    n_rgb = '{red: w_t,    green: r2_p,   blue: r2_val};
            default: n_rgb = '{red: r2_val, green: r2_p,   blue: w_q};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_rgb <= n_rgb;
        end
    end

    assign o_rgb = r3_rgb;

endmodule

// ===== hw/rtl/hsv_rgb_converter_top.sv =====
// Top level of the HSV/RGB pixel converter: stream ports, front stage, output stage.
// Depends on hsvrgb_pkg, hsvrgb_div and hsvrgb_hsv2rgb.
`timescale 1ns / 1ps

// Converts one pixel per clock between HSV and RGB; tuser picks the direction
// (0 = HSV to RGB, 1 = RGB to HSV). The input register loads on the accepting
// edge, then the front stage (max/min, sector, fraction), the 8-stage
// bit-per-stage divider that forms saturation and hue, and the output register
// follow. The HSV to RGB path runs beside the divider and is delayed to line
// up. One item enters per clock while the output is not stalled; the whole
// pipeline holds while a result waits on the output.
module hsv_rgb_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,  // hue_in[8:0], sat_in, val_in, red_in, green_in, blue_in
    input  logic [0:0]  i_s_axis_tuser,  // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata   // red_out, green_out, blue_out, hue_out[8:0], sat_out, val_out
);
    import hsvrgb_pkg::*;

    localparam int RGB_DLY = DIV_STEPS - HSV_LAT;

    logic w_en;

    // Input register
    logic             r_vld_a;
    logic             r_a_cmd;
    logic [HUE_W-1:0] r_a_hue;
    logic [CH_W-1:0]  r_a_sat, r_a_val;
    t_rgb             r_a_pix;

    // Front stage results
    logic             r_vld_b;
    t_side            r_b_side;
    logic [2:0]       r_b_sector;
    logic [CH_W-1:0]  r_b_frac;
    logic [2*CH_W-1:0] r_b_snum, r_b_hnum;
    logic [CH_W-1:0]  r_b_delta;

    logic [HUE_W-1:0] w_hue;
    logic [2:0]       w_sector;
    logic [HUE_W-1:0] w_base60;
    logic [5:0]       w_rem;
    logic [9:0]       w_frac17;
    logic [CH_W-1:0]  w_mx, w_mn, w_delta, w_da, w_db, w_mag;
    t_sel             w_sel;
    logic             w_neg;
    t_side            n_side;

    // Delay line and pipeline valids
    logic             r_vld_d [DIV_STEPS];
    t_side            r_side_d [DIV_STEPS];
    t_rgb             r_rgb_d [RGB_DLY];
    t_rgb             w_rgb_hsv;
    logic [CH_W-1:0]  w_squo, w_hquo;

    // Output stage
    logic             r_vld_o;
    t_rgb             r_o_pix;
    logic [HUE_W-1:0] r_o_hue;
    logic [CH_W-1:0]  r_o_sat, r_o_val;
    t_side            w_fs;
    logic [HUE_W-1:0] n_hue;
    logic [HUE_W-1:0] w_q9;

    // Advance everything unless a result is stuck on the output
    assign w_en            = !r_vld_o || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (w_en) begin
            r_vld_a <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_cmd       <= i_s_axis_tuser[0];
            r_a_hue       <= i_s_axis_tdata[8:0];
            r_a_sat       <= i_s_axis_tdata[16:9];
            r_a_val       <= i_s_axis_tdata[24:17];
            r_a_pix.red   <= i_s_axis_tdata[32:25];
            r_a_pix.green <= i_s_axis_tdata[40:33];
            r_a_pix.blue  <= i_s_axis_tdata[48:41];
        end
    end

    // Front stage: saturate hue, find sector and fraction
    always_comb begin
        w_hue = (r_a_hue > HUE_MAX) ? HUE_MAX : r_a_hue;
        if (w_hue >= 9'd300) begin
            w_sector = 3'd5; w_base60 = 9'd300;
        end else if (w_hue >= HUE_BLUE) begin
            w_sector = 3'd4; w_base60 = HUE_BLUE;
        end else if (w_hue >= 9'd180) begin
            w_sector = 3'd3; w_base60 = 9'd180;
        end else if (w_hue >= HUE_GREEN) begin
            w_sector = 3'd2; w_base60 = HUE_GREEN;
        end else if (w_hue >= 9'd60) begin
            w_sector = 3'd1; w_base60 = 9'd60;
        end else begin
            w_sector = 3'd0; w_base60 = 9'd0;
        end
        w_rem    = 6'(w_hue - w_base60);
        // rem*255/60 equals rem*17/4
        w_frac17 = {4'd0, w_rem} * 10'd17;
    end

    // Front stage: max, min, leading channel, signed hue difference
    always_comb begin
        w_mx = r_a_pix.red;
        if (r_a_pix.green > w_mx) w_mx = r_a_pix.green;
        if (r_a_pix.blue > w_mx)  w_mx = r_a_pix.blue;
        w_mn = r_a_pix.red;
        if (r_a_pix.green < w_mn) w_mn = r_a_pix.green;
        if (r_a_pix.blue < w_mn)  w_mn = r_a_pix.blue;
        w_delta = w_mx - w_mn;

        if (w_mx == r_a_pix.red) begin
            w_sel = SEL_RED;   w_da = r_a_pix.green; w_db = r_a_pix.blue;
        end else if (w_mx == r_a_pix.green) begin
            w_sel = SEL_GREEN; w_da = r_a_pix.blue;  w_db = r_a_pix.red;
        end else begin
            w_sel = SEL_BLUE;  w_da = r_a_pix.red;   w_db = r_a_pix.green;
        end
        w_neg = (w_da < w_db);
        w_mag = w_neg ? (w_db - w_da) : (w_da - w_db);

        n_side.cmd   = r_a_cmd;
        n_side.hue   = w_hue;
        n_side.sat   = r_a_sat;
        n_side.val   = r_a_val;
        n_side.pix   = r_a_pix;
        n_side.mx    = w_mx;
        n_side.sel   = w_sel;
        n_side.neg   = w_neg;
        n_side.dzero = (w_delta == '0);
        n_side.mzero = (w_mx == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (w_en) begin
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_side   <= n_side;
            r_b_sector <= w_sector;
            r_b_frac   <= w_frac17[9:2];
            r_b_delta  <= w_delta;
            r_b_snum   <= 16'(w_delta) * 16'd255;
            r_b_hnum   <= {8'd0, w_mag} * 16'd60;
        end
    end

    // Saturation = delta*255/max
    hsvrgb_div #(.DEN_W(CH_W), .Q_W(DIV_STEPS)) u_div_sat (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_b_snum),
        .i_den (r_b_side.mx),
        .o_quo (w_squo)
    );

    // Hue offset = 60*|difference|/delta
    hsvrgb_div #(.DEN_W(CH_W), .Q_W(DIV_STEPS)) u_div_hue (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_b_hnum),
        .i_den (r_b_delta),
        .o_quo (w_hquo)
    );

    hsvrgb_hsv2rgb u_hsv2rgb (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_sector (r_b_sector),
        .i_frac   (r_b_frac),
        .i_sat    (r_b_side.sat),
        .i_val    (r_b_side.val),
        .o_rgb    (w_rgb_hsv)
    );

    // Carry valid and side data alongside the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_STEPS; i++) begin
                r_vld_d[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld_d[0] <= r_vld_b;
            for (int i = 1; i < DIV_STEPS; i++) begin
                r_vld_d[i] <= r_vld_d[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side_d[0] <= r_b_side;
            for (int i = 1; i < DIV_STEPS; i++) begin
                r_side_d[i] <= r_side_d[i-1];
            end
            r_rgb_d[0] <= w_rgb_hsv;
            for (int i = 1; i < RGB_DLY; i++) begin
                r_rgb_d[i] <= r_rgb_d[i-1];
            end
        end
    end

    // Output stage: place the hue offset around the leading channel
    assign w_fs = r_side_d[DIV_STEPS-1];
    assign w_q9 = {1'b0, w_hquo};

    always_comb begin
        if (w_fs.dzero) begin
            n_hue = '0;
        end else begin
            case (w_fs.sel)
                SEL_RED:   n_hue = w_fs.neg ? ((w_q9 == '0) ? '0 : HUE_FULL - w_q9) : w_q9;
                SEL_GREEN: n_hue = w_fs.neg ? (HUE_GREEN - w_q9) : (HUE_GREEN + w_q9);
                default:   n_hue = w_fs.neg ? (HUE_BLUE - w_q9) : (HUE_BLUE + w_q9);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else if (w_en) begin
            r_vld_o <= r_vld_d[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_fs.cmd == CMD_RGB2HSV) begin
                r_o_pix <= w_fs.pix;
                r_o_hue <= n_hue;
                r_o_sat <= w_fs.mzero ? '0 : w_squo;
                r_o_val <= w_fs.mx;
            end else begin
                r_o_pix <= r_rgb_d[RGB_DLY-1];
                r_o_hue <= w_fs.hue;
                r_o_sat <= w_fs.sat;
                r_o_val <= w_fs.val;
            end
        end
    end

    assign o_m_axis_tvalid = r_vld_o;
    assign o_m_axis_tdata  = {7'd0, r_o_val, r_o_sat, r_o_hue,
                              r_o_pix.blue, r_o_pix.green, r_o_pix.red};

endmodule
